// ===== rtl/battery_level_estimator_macros.svh =====
// ----------------------------------------------------------------------------
// Battery level estimator assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_ESTIMATOR_MACROS_SVH
`define BATTERY_LEVEL_ESTIMATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BLE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BLE_ASSERT(lbl, prop, msg)
`define BLE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator package
// Widths, reset values, register codes and request/response types.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int PCT_W     = 7;
    localparam int PCT_FULL  = 100;
    localparam int MAX_TOTAL = PCT_FULL * WINDOW_DEPTH;
    localparam int TOTAL_W   = $clog2(MAX_TOTAL + 1);

    localparam int TIME_W  = 48;
    localparam int MV_W    = 16;
    localparam int CUR_W   = 16;
    localparam int THR_W   = 15;
    localparam int STEP_W  = 32;
    localparam int PORT_W  = 8;
    localparam int ACC_W   = STEP_W + CNT_W;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int USB_BIT      = 2;
    localparam int WIRELESS_BIT = 3;

    // serial divider: quotient is known to stay below 2**QUO_W
    localparam int QUO_W      = PCT_W;
    localparam int QBIT_W     = $clog2(QUO_W);
    localparam int DIVISOR_W  = MV_W;
    localparam int DIVIDEND_W = MV_W + PCT_W;

    localparam logic [MV_W-1:0]   EMPTY_MV_RST  = MV_W'(3300);
    localparam logic [MV_W-1:0]   FULL_MV_RST   = MV_W'(4200);
    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(5);
    localparam logic [STEP_W-1:0] STEP_US_RST   = STEP_W'(1000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_MV  = 2'd0,
        CFG_FULL_MV   = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_STEP_US   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_resp_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] last;
        logic [STEP_W-1:0] step;
    } steps_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] count;
    } steps_resp_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(WINDOW_DEPTH - 1))
            res = '0;
        else
            res = slot + SLOT_W'(1);
        return res;
    endfunction

endpackage

// ===== rtl/ble_if.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator channels
// Poll channel into the block and status channel out of it.
// ----------------------------------------------------------------------------
interface ble_poll_if;
    logic                               valid;
    logic                               ready;
    logic [ble_pkg::TIME_W-1:0]         timestamp_us;
    logic                               voltage_valid;
    logic [ble_pkg::MV_W-1:0]           batt_mv;
    logic                               current_valid;
    logic signed [ble_pkg::CUR_W-1:0]   batt_ma;
    logic                               port_valid;
    logic [ble_pkg::PORT_W-1:0]         port_bits;

    modport source (
        output valid, timestamp_us, voltage_valid, batt_mv,
               current_valid, batt_ma, port_valid, port_bits,
        input  ready
    );
    modport sink (
        input  valid, timestamp_us, voltage_valid, batt_mv,
               current_valid, batt_ma, port_valid, port_bits,
        output ready
    );
endinterface

interface ble_status_if;
    logic                        valid;
    logic                        ready;
    logic [ble_pkg::PCT_W-1:0]   level_percent;
    logic                        level_available;
    logic                        is_charging;
    logic                        is_discharging;
    logic                        direction_available;
    logic                        external_power;
    logic                        external_power_known;

    modport source (
        output valid, level_percent, level_available, is_charging, is_discharging,
               direction_available, external_power, external_power_known,
        input  ready
    );
    modport sink (
        input  valid, level_percent, level_available, is_charging, is_discharging,
               direction_available, external_power, external_power_known,
        output ready
    );
endinterface

// ===== rtl/ble_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ble_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, for quotients below 2**QUO_W.
// ----------------------------------------------------------------------------
module ble_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ble_pkg::div_req_t  req,
    output ble_pkg::div_resp_t resp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ble_pkg::DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [ble_pkg::DIVISOR_W-1:0]  den_reg, den_next;
    logic [ble_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [ble_pkg::QBIT_W-1:0]     bit_reg, bit_next;
    logic [ble_pkg::DIVIDEND_W-1:0] trial;

    assign trial = ble_pkg::DIVIDEND_W'(den_reg) << bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = req.dividend;
            den_next  = req.divisor;
            quo_next  = '0;
            bit_next  = ble_pkg::QBIT_W'(ble_pkg::QUO_W - 1);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                quo_next = quo_reg | (ble_pkg::QUO_W'(1) << bit_reg);
            end
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_next = bit_reg - ble_pkg::QBIT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
    end

    assign resp.busy     = busy_reg;
    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

// ===== rtl/ble_steps.sv =====
// ----------------------------------------------------------------------------
// Elapsed step counter
// Counts whole step intervals since the last update, one add and compare a
// cycle, clamped to the window depth and never below one.
// ----------------------------------------------------------------------------
module ble_steps (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ble_pkg::steps_req_t  req,
    output ble_pkg::steps_resp_t resp
);

    localparam int CMP_W = ble_pkg::TIME_W + 1;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CMP_W-1:0]           delta_reg, delta_next;
    logic [ble_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [ble_pkg::STEP_W-1:0] inc_reg, inc_next;
    logic [ble_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ble_pkg::STEP_W-1:0] step_nz;
    logic                       stop;

    // a zero interval counts as one microsecond
    assign step_nz = (req.step == '0) ? ble_pkg::STEP_W'(1) : req.step;

    // time going backwards leaves the borrow bit set: one step
    assign stop = delta_reg[ble_pkg::TIME_W]
               || (CMP_W'(acc_reg) > delta_reg)
               || (cnt_reg == ble_pkg::CNT_W'(ble_pkg::WINDOW_DEPTH));

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        delta_next = delta_reg;
        acc_next   = acc_reg;
        inc_next   = inc_reg;
        cnt_next   = cnt_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            delta_next = {1'b0, req.now} - {1'b0, req.last};
            acc_next   = ble_pkg::ACC_W'(step_nz);
            inc_next   = step_nz;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            if (stop)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next = ble_pkg::CNT_W'(1);
                end
            end
            else
            begin
                cnt_next = cnt_reg + ble_pkg::CNT_W'(1);
                acc_next = acc_reg + ble_pkg::ACC_W'(inc_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
        inc_reg   <= inc_next;
        cnt_reg   <= cnt_next;
    end

    assign resp.busy  = busy_reg;
    assign resp.done  = done_reg;
    assign resp.count = cnt_reg;

endmodule

// ===== rtl/battery_level_estimator.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator
// One poll item in, one status item out, one poll at a time. A poll without
// voltage goes straight to its status item. The first voltage poll runs the
// percent division when the voltage lies between empty and full, then writes
// every window slot; later ones run the division, the step count and, per
// counted step, a slot RAM read-modify-write (S_RD, then S_WR). The next poll
// is taken in the cycle the status item appears, unless an unread status item
// holds the block in S_DONE. Reset is asynchronous, active low, and clears all
// control state; the window RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "battery_level_estimator_macros.svh"

module battery_level_estimator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ble_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ble_pkg::CFG_W-1:0]         cfg_data,
    ble_poll_if.sink                          poll,
    ble_status_if.source                      status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PCT,
        S_DIVP_GO,
        S_DIVP_WAIT,
        S_AVG,
        S_FILL,
        S_STEPS_WAIT,
        S_RD,
        S_WR,
        S_MEAN,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ble_pkg::MV_W-1:0]   empty_mv_reg;
    logic [ble_pkg::MV_W-1:0]   full_mv_reg;
    logic [ble_pkg::THR_W-1:0]  thr_reg;
    logic [ble_pkg::STEP_W-1:0] step_us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_mv_reg <= ble_pkg::EMPTY_MV_RST;
            full_mv_reg  <= ble_pkg::FULL_MV_RST;
            thr_reg      <= ble_pkg::THRESHOLD_RST;
            step_us_reg  <= ble_pkg::STEP_US_RST;
        end
        else if (cfg_we)
        begin
            case (ble_pkg::cfg_index_t'(cfg_index))
                ble_pkg::CFG_EMPTY_MV:  empty_mv_reg <= cfg_data[ble_pkg::MV_W-1:0];
                ble_pkg::CFG_FULL_MV:   full_mv_reg  <= cfg_data[ble_pkg::MV_W-1:0];
                ble_pkg::CFG_THRESHOLD: thr_reg      <= cfg_data[ble_pkg::THR_W-1:0];
                ble_pkg::CFG_STEP_US:   step_us_reg  <= cfg_data[ble_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State, held item fields and status flags
    // ------------------------------------------------------------------
    state_t                           state_reg, state_next;
    logic [ble_pkg::TIME_W-1:0]       now_reg, now_next;
    logic                             vvalid_reg, vvalid_next;
    logic [ble_pkg::MV_W-1:0]         mv_reg, mv_next;
    logic [ble_pkg::PCT_W-1:0]        pct_reg, pct_next;
    logic [ble_pkg::DIVIDEND_W-1:0]   num_reg, num_next;
    logic [ble_pkg::CNT_W-1:0]        step_cnt_reg, step_cnt_next;

    logic [ble_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic [ble_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [ble_pkg::TIME_W-1:0]       last_reg, last_next;
    logic                             primed_reg, primed_next;
    logic [ble_pkg::PCT_W-1:0]        held_reg, held_next;
    logic                             lvl_seen_reg, lvl_seen_next;
    logic                             chg_reg, chg_next;
    logic                             dis_reg, dis_next;
    logic                             dir_seen_reg, dir_seen_next;
    logic                             pwr_reg, pwr_next;
    logic                             pwr_seen_reg, pwr_seen_next;

    // registered status item
    logic                             out_valid_reg, out_valid_next;
    logic [ble_pkg::PCT_W-1:0]        out_pct_reg, out_pct_next;
    logic                             out_lvl_reg, out_lvl_next;
    logic                             out_chg_reg, out_chg_next;
    logic                             out_dis_reg, out_dis_next;
    logic                             out_dir_reg, out_dir_next;
    logic                             out_pwr_reg, out_pwr_next;
    logic                             out_pwk_reg, out_pwk_next;

    // ------------------------------------------------------------------
    // Shared units and window RAM
    // ------------------------------------------------------------------
    ble_pkg::div_req_t     div_req;
    ble_pkg::div_resp_t    div_resp;
    ble_pkg::steps_req_t   steps_req;
    ble_pkg::steps_resp_t  steps_resp;

    logic                       ram_we;
    logic [ble_pkg::PCT_W-1:0]  ram_rdata;

    ble_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    ble_steps u_steps (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (steps_req),
        .resp  (steps_resp)
    );

    // the window slots; read port always points at the current slot so the
    // old value is registered out in the cycle after the slot settles
    ble_ram #(
        .WIDTH (ble_pkg::PCT_W),
        .DEPTH (ble_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (pct_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign ram_we = (state_reg == S_FILL) || (state_reg == S_WR);

    // percent division, started in S_DIVP_GO
    always_comb
    begin
        div_req.start    = (state_reg == S_DIVP_GO);
        div_req.dividend = num_reg;
        div_req.divisor  = full_mv_reg - empty_mv_reg;
    end

    assign steps_req.start = (state_reg == S_AVG) && primed_reg;
    assign steps_req.now   = now_reg;
    assign steps_req.last  = last_reg;
    assign steps_req.step  = step_us_reg;

    // ------------------------------------------------------------------
    // Immediate classification of current and port bits at accept
    // ------------------------------------------------------------------
    logic                            accept;
    logic signed [ble_pkg::CUR_W:0]  cur_ext;
    logic signed [ble_pkg::CUR_W:0]  thr_pos;
    logic [ble_pkg::MV_W-1:0]        span;
    logic [ble_pkg::MV_W-1:0]        over_empty;

    assign accept     = poll.valid && poll.ready;
    assign cur_ext    = {poll.batt_ma[ble_pkg::CUR_W-1], poll.batt_ma};
    assign thr_pos    = $signed({2'b00, thr_reg});
    assign span       = full_mv_reg - empty_mv_reg;
    assign over_empty = mv_reg - empty_mv_reg;

    assign poll.ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        vvalid_next    = vvalid_reg;
        mv_next        = mv_reg;
        pct_next       = pct_reg;
        num_next       = num_reg;
        step_cnt_next  = step_cnt_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        primed_next    = primed_reg;
        held_next      = held_reg;
        lvl_seen_next  = lvl_seen_reg;
        chg_next       = chg_reg;
        dis_next       = dis_reg;
        dir_seen_next  = dir_seen_reg;
        pwr_next       = pwr_reg;
        pwr_seen_next  = pwr_seen_reg;
        out_valid_next = out_valid_reg && !status.ready;
        out_pct_next   = out_pct_reg;
        out_lvl_next   = out_lvl_reg;
        out_chg_next   = out_chg_reg;
        out_dis_next   = out_dis_reg;
        out_dir_next   = out_dir_reg;
        out_pwr_next   = out_pwr_reg;
        out_pwk_next   = out_pwk_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next    = poll.timestamp_us;
                    vvalid_next = poll.voltage_valid;
                    mv_next     = poll.batt_mv;
                    // port and current flags settle now; the voltage path runs on
                    if (poll.port_valid)
                    begin
                        pwr_next      = poll.port_bits[ble_pkg::USB_BIT]
                                     || poll.port_bits[ble_pkg::WIRELESS_BIT];
                        pwr_seen_next = 1'b1;
                    end
                    if (poll.current_valid)
                    begin
                        chg_next      = cur_ext > thr_pos;
                        dis_next      = cur_ext < -thr_pos;
                        dir_seen_next = 1'b1;
                    end
                    state_next = S_PCT;
                end
            end

            S_PCT:
            begin
                if (!vvalid_reg)
                begin
                    state_next = S_DONE;
                end
                else if (mv_reg <= empty_mv_reg)
                begin
                    pct_next   = '0;
                    state_next = S_AVG;
                end
                else if (mv_reg >= full_mv_reg)
                begin
                    pct_next   = ble_pkg::PCT_W'(ble_pkg::PCT_FULL);
                    state_next = S_AVG;
                end
                else
                begin
                    // rounded (mv - empty) * 100 / span
                    num_next   = ble_pkg::DIVIDEND_W'(over_empty)
                               * ble_pkg::DIVIDEND_W'(ble_pkg::PCT_FULL)
                               + ble_pkg::DIVIDEND_W'(span >> 1);
                    state_next = S_DIVP_GO;
                end
            end

            S_DIVP_GO:
            begin
                state_next = S_DIVP_WAIT;
            end

            S_DIVP_WAIT:
            begin
                if (div_resp.done)
                begin
                    pct_next   = div_resp.quotient;
                    state_next = S_AVG;
                end
            end

            S_AVG:
            begin
                if (!primed_reg)
                begin
                    // first sample: write every slot
                    step_cnt_next = ble_pkg::CNT_W'(ble_pkg::WINDOW_DEPTH);
                    state_next    = S_FILL;
                end
                else
                begin
                    last_next  = now_reg;
                    state_next = S_STEPS_WAIT;
                end
            end

            S_FILL:
            begin
                slot_next     = ble_pkg::next_slot(slot_reg);
                step_cnt_next = step_cnt_reg - ble_pkg::CNT_W'(1);
                if (step_cnt_reg == ble_pkg::CNT_W'(1))
                begin
                    total_next    = ble_pkg::TOTAL_W'(pct_reg)
                                  * ble_pkg::TOTAL_W'(ble_pkg::WINDOW_DEPTH);
                    slot_next     = '0;
                    last_next     = now_reg;
                    primed_next   = 1'b1;
                    held_next     = pct_reg;
                    lvl_seen_next = 1'b1;
                    state_next    = S_DONE;
                end
            end

            S_STEPS_WAIT:
            begin
                if (steps_resp.done)
                begin
                    step_cnt_next = steps_resp.count;
                    state_next    = S_RD;
                end
            end

            S_RD:
            begin
                // RAM is reading the current slot; data is there next cycle
                state_next = S_WR;
            end

            S_WR:
            begin
                total_next    = total_reg - ble_pkg::TOTAL_W'(ram_rdata)
                              + ble_pkg::TOTAL_W'(pct_reg);
                slot_next     = ble_pkg::next_slot(slot_reg);
                step_cnt_next = step_cnt_reg - ble_pkg::CNT_W'(1);
                if (step_cnt_reg == ble_pkg::CNT_W'(1))
                    state_next = S_MEAN;
                else
                    state_next = S_RD;
            end

            S_MEAN:
            begin
                // rounded mean; the depth is a power of two, so this is a shift
                held_next     = ble_pkg::PCT_W'(
                                    (total_reg
                                     + ble_pkg::TOTAL_W'(ble_pkg::WINDOW_DEPTH / 2))
                                    / ble_pkg::TOTAL_W'(ble_pkg::WINDOW_DEPTH));
                lvl_seen_next = 1'b1;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // load the status item once the output register is free
                if (!out_valid_reg || status.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pct_next   = held_reg;
                    out_lvl_next   = lvl_seen_reg;
                    out_chg_next   = chg_reg;
                    out_dis_next   = dis_reg;
                    out_dir_next   = dir_seen_reg;
                    out_pwr_next   = pwr_reg;
                    out_pwk_next   = pwr_seen_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            vvalid_reg    <= 1'b0;
            mv_reg        <= '0;
            pct_reg       <= '0;
            num_reg       <= '0;
            step_cnt_reg  <= '0;
            total_reg     <= '0;
            slot_reg      <= '0;
            last_reg      <= '0;
            primed_reg    <= 1'b0;
            held_reg      <= '0;
            lvl_seen_reg  <= 1'b0;
            chg_reg       <= 1'b0;
            dis_reg       <= 1'b0;
            dir_seen_reg  <= 1'b0;
            pwr_reg       <= 1'b0;
            pwr_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pct_reg   <= '0;
            out_lvl_reg   <= 1'b0;
            out_chg_reg   <= 1'b0;
            out_dis_reg   <= 1'b0;
            out_dir_reg   <= 1'b0;
            out_pwr_reg   <= 1'b0;
            out_pwk_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            vvalid_reg    <= vvalid_next;
            mv_reg        <= mv_next;
            pct_reg       <= pct_next;
            num_reg       <= num_next;
            step_cnt_reg  <= step_cnt_next;
            total_reg     <= total_next;
            slot_reg      <= slot_next;
            last_reg      <= last_next;
            primed_reg    <= primed_next;
            held_reg      <= held_next;
            lvl_seen_reg  <= lvl_seen_next;
            chg_reg       <= chg_next;
            dis_reg       <= dis_next;
            dir_seen_reg  <= dir_seen_next;
            pwr_reg       <= pwr_next;
            pwr_seen_reg  <= pwr_seen_next;
            out_valid_reg <= out_valid_next;
            out_pct_reg   <= out_pct_next;
            out_lvl_reg   <= out_lvl_next;
            out_chg_reg   <= out_chg_next;
            out_dis_reg   <= out_dis_next;
            out_dir_reg   <= out_dir_next;
            out_pwr_reg   <= out_pwr_next;
            out_pwk_reg   <= out_pwk_next;
        end
    end

    assign status.valid                = out_valid_reg;
    assign status.level_percent        = out_pct_reg;
    assign status.level_available      = out_lvl_reg;
    assign status.is_charging          = out_chg_reg;
    assign status.is_discharging       = out_dis_reg;
    assign status.direction_available  = out_dir_reg;
    assign status.external_power       = out_pwr_reg;
    assign status.external_power_known = out_pwk_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BLE_ASSERT(a_ram_we_state, ram_we |-> (state_reg == S_FILL || state_reg == S_WR), "window write outside fill or update")
    `BLE_ASSERT(a_total_bound, total_reg <= ble_pkg::TOTAL_W'(ble_pkg::MAX_TOTAL), "window total out of range")
    `BLE_ASSERT(a_wr_count, (state_reg == S_WR) |-> (step_cnt_reg != '0), "slot update with no steps left")
    `BLE_ASSERT(a_div_idle, div_req.start |-> !div_resp.busy, "divider started while busy")
    `BLE_ASSERT_NEXT(a_accept_hold, poll.valid && poll.ready, !poll.ready, "second item taken while busy")

endmodule
